// ----- rtl/core/ntfp_pkg.sv -----
package ntfp_pkg;

    // Default configuration
    localparam int FRAC_BITS_DEF       = 24;
    localparam int MAX_FRAC_DIGITS_DEF = 15;
    localparam int MAX_LENGTH_DEF      = 255;

    // Character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_MALFORMED  = 2'd2;

    // Parser command from the sequencer
    typedef struct packed {
        logic clear;
        logic prefix;
        logic hex;
        logic feed;
    } t_pcmd;

    // Parser summary towards the sequencer
    typedef struct packed {
        logic       negative;
        logic [1:0] status;
    } t_pstat;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } t_digit;

    // Map a character to a digit of the current base
    function automatic t_digit digit_of(input logic [7:0] ch, input logic hex);
        t_digit d;
        d.valid = 1'b0;
        d.val   = 4'd0;
        if (ch >= CH_0 && ch <= CH_9) begin
            d.valid = 1'b1;
            d.val   = 4'(ch - CH_0);
        end else if (hex && ch >= CH_LA && ch <= CH_LF) begin
            d.valid = 1'b1;
            d.val   = 4'(ch - CH_LA + 8'd10);
        end else if (hex && ch >= CH_UA && ch <= CH_UF) begin
            d.valid = 1'b1;
            d.val   = 4'(ch - CH_UA + 8'd10);
        end
        return d;
    endfunction

endpackage

// ----- rtl/core/ntfp_parse.sv -----
module ntfp_parse import ntfp_pkg::*; #(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
    parameter int MAX_LENGTH      = MAX_LENGTH_DEF,
    localparam int INT_W = 63 - FRAC_BITS,
    localparam int NUM_W = 4 * MAX_FRAC_DIGITS,
    localparam int SCL_W = NUM_W + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pcmd              i_cmd,
    input  logic [7:0]         i_ch,
    output logic [INT_W-1:0]   o_int,
    output logic [NUM_W-1:0]   o_num,
    output logic [SCL_W-1:0]   o_scale,
    output logic [7:0]         o_count,
    output t_pstat             o_stat
);

    localparam int DIG_W = $clog2(MAX_FRAC_DIGITS + 1);
    localparam logic [7:0] CNT_CAP = 8'((MAX_LENGTH < 255) ? MAX_LENGTH : 255);

    localparam logic [1:0] PH_SIGN  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_NUM   = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [1:0]       r_phase, n_phase;
    logic             r_hex, n_hex;
    logic             r_neg, n_neg;
    logic             r_dot, n_dot;
    logic             r_bad, n_bad;
    logic [INT_W-1:0] r_int, n_int;
    logic [NUM_W-1:0] r_num, n_num;
    logic [SCL_W-1:0] r_scl, n_scl;
    logic [DIG_W-1:0] r_fd, n_fd;
    logic [7:0]       r_cnt, n_cnt;

    logic [1:0]       eff_phase;
    t_digit           dig;
    logic [7:0]       cnt_inc;

    assign eff_phase = (r_phase == PH_SIGN) ? PH_FIRST : r_phase;
    assign dig       = digit_of(i_ch, r_hex);
    assign cnt_inc   = (r_cnt < CNT_CAP) ? r_cnt + 8'd1 : r_cnt;

    // Clear the parse, apply a prefix, or step it by one character
    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        n_neg   = r_neg;
        n_dot   = r_dot;
        n_bad   = r_bad;
        n_int   = r_int;
        n_num   = r_num;
        n_scl   = r_scl;
        n_fd    = r_fd;
        n_cnt   = r_cnt;
        if (i_cmd.clear) begin
            n_phase = PH_SIGN;
            n_hex   = 1'b0;
            n_neg   = 1'b0;
            n_dot   = 1'b0;
            n_bad   = 1'b0;
            n_int   = '0;
            n_num   = '0;
            n_scl   = SCL_W'(1);
            n_fd    = '0;
            n_cnt   = 8'd0;
        end else if (i_cmd.prefix) begin
            n_hex = i_cmd.hex;
            n_cnt = 8'd3;
        end else if (i_cmd.feed && r_phase != PH_DONE) begin
            if (r_phase == PH_SIGN && (i_ch == CH_MINUS || i_ch == CH_PLUS)) begin
                n_neg   = (i_ch == CH_MINUS);
                n_cnt   = cnt_inc;
                n_phase = PH_FIRST;
            end else begin
                n_phase = eff_phase;
                if (dig.valid) begin
                    if (r_dot) begin
                        if (r_fd < DIG_W'(MAX_FRAC_DIGITS)) begin
                            if (r_hex) begin
                                n_num = (r_num << 4) + NUM_W'(dig.val);
                                n_scl = r_scl << 4;
                            end else begin
                                n_num = (r_num << 3) + (r_num << 1) + NUM_W'(dig.val);
                                n_scl = (r_scl << 3) + (r_scl << 1);
                            end
                            n_fd = r_fd + DIG_W'(1);
                        end
                    end else if (r_hex) begin
                        n_int = (r_int << 4) + INT_W'(dig.val);
                    end else begin
                        n_int = (r_int << 3) + (r_int << 1) + INT_W'(dig.val);
                    end
                    n_cnt   = cnt_inc;
                    n_phase = PH_NUM;
                end else if (i_ch == CH_DOT) begin
                    if (eff_phase == PH_FIRST || r_dot) begin
                        n_bad   = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_dot = 1'b1;
                        n_cnt = cnt_inc;
                    end
                end else begin
                    if (eff_phase == PH_FIRST) begin
                        n_bad = 1'b1;
                    end
                    n_phase = PH_DONE;
                end
            end
        end
    end

    // Hold control state and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIGN;
            r_hex   <= 1'b0;
            r_neg   <= 1'b0;
            r_dot   <= 1'b0;
            r_bad   <= 1'b0;
            r_fd    <= '0;
            r_cnt   <= 8'd0;
            r_int   <= '0;
            r_num   <= '0;
            r_scl   <= SCL_W'(1);
        end else begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_neg   <= n_neg;
            r_dot   <= n_dot;
            r_bad   <= n_bad;
            r_fd    <= n_fd;
            r_cnt   <= n_cnt;
            r_int   <= n_int;
            r_num   <= n_num;
            r_scl   <= n_scl;
        end
    end

    assign o_int   = r_int;
    assign o_num   = r_num;
    assign o_scale = r_scl;
    assign o_count = r_cnt;
    assign o_stat.negative = r_neg;
    assign o_stat.status   = (r_phase == PH_SIGN || r_phase == PH_FIRST) ? ST_INCOMPLETE :
                             r_bad ? ST_MALFORMED : ST_OK;

endmodule

// ----- rtl/core/ntfp_div.sv -----
module ntfp_div import ntfp_pkg::*; #(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
    localparam int NUM_W = 4 * MAX_FRAC_DIGITS,
    localparam int SCL_W = NUM_W + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_W-1:0]     i_num,
    input  logic [SCL_W-1:0]     i_scale,
    output logic                 o_busy,
    output logic [FRAC_BITS-1:0] o_quot
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [SCL_W-1:0]     r_rem;
    logic [SCL_W-1:0]     r_den;
    logic [FRAC_BITS-1:0] r_quot;

    logic [SCL_W:0]       trial;
    logic                 fits;

    // Shared shift, compare and subtract step
    assign trial = {r_rem, 1'b0};
    assign fits  = (trial >= {1'b0, r_den});

    // Control: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(FRAC_BITS);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    // Datapath: restoring division
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= SCL_W'(i_num);
            r_den  <= i_scale;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? SCL_W'(trial - {1'b0, r_den}) : SCL_W'(trial);
            r_quot <= (r_quot << 1) | FRAC_BITS'(fits);
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// ----- rtl/core/numeric_text_to_fixed_point.sv -----
// Parses a numeric string, one character per beat with i_last on the final one, into a
// 64-bit two's complement value with FRAC_BITS fraction bits. An optional "16#" or "10#"
// prefix (only in strings longer than three characters), a sign, digits and at most one
// dot are taken; the first other character ends the number. o_status is 0 ok, 1 nothing
// after prefix or sign, 2 malformed; o_value and o_consumed are zero unless ok.
// Timing: the first three characters are buffered at one per cycle; the fourth (or the
// last of a shorter string) stalls the input while the buffer replays through the parser,
// one character a cycle (only the fourth when a prefix is found). Later characters go in
// one per cycle. After the last character, input stalls while the shared restoring
// divider forms the fraction one bit per cycle, and while the output register has not
// yet drained.
module numeric_text_to_fixed_point import ntfp_pkg::*; #(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
    parameter int MAX_LENGTH      = MAX_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_value,
    output logic [1:0]  o_status,
    output logic [7:0]  o_consumed
);

    localparam int INT_W = 63 - FRAC_BITS;
    localparam int NUM_W = 4 * MAX_FRAC_DIGITS;
    localparam int SCL_W = NUM_W + 1;

    localparam logic [2:0] S_HEAD   = 3'd0;
    localparam logic [2:0] S_REPLAY = 3'd1;
    localparam logic [2:0] S_RUN    = 3'd2;
    localparam logic [2:0] S_CAPT   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [1:0]       r_head_n, n_head_n;
    logic [1:0]       r_rp, n_rp;
    logic [1:0]       r_rend, n_rend;
    logic             r_last, n_last;
    logic [7:0]       r_q [4];
    logic             q_wr;
    logic [1:0]       q_wa;

    logic             in_acc;
    logic             is_prefix;
    t_pcmd            pcmd;
    logic [7:0]       feed_ch;

    logic [INT_W-1:0] p_int;
    logic [NUM_W-1:0] p_num;
    logic [SCL_W-1:0] p_scale;
    logic [7:0]       p_count;
    t_pstat           p_stat;

    logic             div_start;
    logic             div_busy;
    logic [FRAC_BITS-1:0] div_quot;

    logic [INT_W-1:0] r_int;
    logic [7:0]       r_count;
    t_pstat           r_stat;

    logic             out_load;
    logic             r_out_valid;
    logic [63:0]      r_value;
    logic [1:0]       r_status;
    logic [7:0]       r_consumed;
    logic [63:0]      mag;

    assign o_in_stall = !(r_state == S_HEAD || r_state == S_RUN);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_prefix  = (r_q[2] == CH_HASH) && (r_q[0] == CH_1) &&
                        (r_q[1] == CH_6 || r_q[1] == CH_0);
    assign out_load   = (r_state == S_DIV) && !div_busy &&
                        (!r_out_valid || !i_out_stall);
    assign div_start  = (r_state == S_CAPT);

    // Sequence head buffering, replay, feeding and division
    always_comb begin
        n_state  = r_state;
        n_head_n = r_head_n;
        n_rp     = r_rp;
        n_rend   = r_rend;
        n_last   = r_last;
        q_wr     = 1'b0;
        q_wa     = r_head_n;
        pcmd     = '0;
        feed_ch  = i_ch;
        case (r_state)
            S_HEAD: begin
                if (in_acc) begin
                    q_wr = 1'b1;
                    if (r_head_n == 2'd3 || i_last) begin
                        n_rend  = r_head_n;
                        n_last  = i_last;
                        n_state = S_REPLAY;
                        if (r_head_n == 2'd3 && is_prefix) begin
                            pcmd.prefix = 1'b1;
                            pcmd.hex    = (r_q[1] == CH_6);
                            n_rp        = 2'd3;
                        end else begin
                            n_rp = 2'd0;
                        end
                    end else begin
                        n_head_n = r_head_n + 2'd1;
                    end
                end
            end
            S_REPLAY: begin
                pcmd.feed = 1'b1;
                feed_ch   = r_q[r_rp];
                if (r_rp == r_rend) begin
                    n_state = r_last ? S_CAPT : S_RUN;
                end else begin
                    n_rp = r_rp + 2'd1;
                end
            end
            S_RUN: begin
                if (in_acc) begin
                    pcmd.feed = 1'b1;
                    if (i_last) begin
                        n_state = S_CAPT;
                    end
                end
            end
            S_CAPT: begin
                pcmd.clear = 1'b1;
                n_head_n   = 2'd0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (out_load) begin
                    n_state = S_HEAD;
                end
            end
            default: begin
                n_state = S_HEAD;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_HEAD;
            r_head_n <= 2'd0;
            r_rp     <= 2'd0;
            r_rend   <= 2'd0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head_n <= n_head_n;
            r_rp     <= n_rp;
            r_rend   <= n_rend;
            r_last   <= n_last;
        end
    end

    // Hold buffered head characters
    always_ff @(posedge i_clk) begin
        if (q_wr) begin
            r_q[q_wa] <= i_ch;
        end
    end

    ntfp_parse #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .MAX_LENGTH      (MAX_LENGTH)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pcmd),
        .i_ch    (feed_ch),
        .o_int   (p_int),
        .o_num   (p_num),
        .o_scale (p_scale),
        .o_count (p_count),
        .o_stat  (p_stat)
    );

    ntfp_div #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (p_num),
        .i_scale (p_scale),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // Capture the parse summary while the divider runs
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_int   <= p_int;
            r_count <= p_count;
            r_stat  <= p_stat;
        end
    end

    // Pack integer and fraction; bit 63 stays clear
    assign mag = {1'b0, r_int, div_quot};

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_status <= r_stat.status;
            if (r_stat.status == ST_OK) begin
                r_value    <= r_stat.negative ? 64'd0 - mag : mag;
                r_consumed <= r_count;
            end else begin
                r_value    <= 64'd0;
                r_consumed <= 8'd0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;
    assign o_consumed  = r_consumed;

endmodule

// ----- sim/numeric_text_to_fixed_point_tb.sv -----
module numeric_text_to_fixed_point_tb import ntfp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int INT_W   = 63 - FRAC_BITS_DEF;
    localparam int CNT_MAX = (MAX_LENGTH_DEF < 255) ? MAX_LENGTH_DEF : 255;

    typedef enum logic [2:0] {P_HEAD, P_SIGN, P_FIRST, P_NUM, P_DONE} t_parse_phase;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        int         gap;
        bit         drain;
    } t_char_beat;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  status;
        logic [7:0]  consumed;
    } t_fixed_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_ch        = 8'h00;
    logic        i_last      = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_value;
    logic [1:0]  o_status;
    logic [7:0]  o_consumed;

    t_char_beat    pend_q[$];
    t_fixed_result exp_q[$];
    t_char_beat    next_beat;

    int beats_in    = 0;
    int results_n   = 0;
    int strings_n   = 0;
    int error_n     = 0;
    int quiet_from  = 1 << 30;
    int stall_left  = 0;

    // Parser state of the prediction
    t_parse_phase ph;
    logic [7:0]   head_buf [3];
    int           head_n;
    bit           hex_on;
    bit           neg_on;
    bit           dot_on;
    bit           bad_on;
    logic [63:0]  int_acc;
    logic [63:0]  frac_num;
    logic [63:0]  frac_scale;
    int           frac_n;
    int           char_n;

    numeric_text_to_fixed_point DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_status    (o_status),
        .o_consumed  (o_consumed)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        ph         = P_HEAD;
        head_buf   = '{8'h00, 8'h00, 8'h00};
        head_n     = 0;
        hex_on     = 1'b0;
        neg_on     = 1'b0;
        dot_on     = 1'b0;
        bad_on     = 1'b0;
        int_acc    = 64'd0;
        frac_num   = 64'd0;
        frac_scale = 64'd1;
        frac_n     = 0;
        char_n     = 0;
    endfunction

    function automatic void count_char();
        if (char_n < CNT_MAX) char_n++;
    endfunction

    // Digit value in the current base, -1 when not a digit
    function automatic int digit_val(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (hex_on && c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        if (hex_on && c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    // Advance the number parser by one character
    function automatic void parse_char(input logic [7:0] c);
        logic [63:0] base;
        int          d;
        base = hex_on ? 64'd16 : 64'd10;
        if (ph == P_DONE || ph == P_HEAD) return;
        if (ph == P_SIGN) begin
            ph = P_FIRST;
            if (c == CH_MINUS || c == CH_PLUS) begin
                neg_on = (c == CH_MINUS);
                count_char();
                return;
            end
        end
        d = digit_val(c);
        if (d >= 0) begin
            if (dot_on) begin
                if (frac_n < MAX_FRAC_DIGITS_DEF) begin
                    frac_num   = frac_num * base + 64'(d);
                    frac_scale = frac_scale * base;
                    frac_n++;
                end
            end else begin
                int_acc = (int_acc * base + 64'(d)) & ((64'd1 << INT_W) - 64'd1);
            end
            count_char();
            ph = P_NUM;
        end else if (c == CH_DOT) begin
            if (ph == P_FIRST || dot_on) begin
                bad_on = 1'b1;
                ph     = P_DONE;
            end else begin
                dot_on = 1'b1;
                count_char();
            end
        end else begin
            if (ph == P_FIRST) bad_on = 1'b1;
            ph = P_DONE;
        end
    endfunction

    // Exact floor(num * 2^FRAC_BITS / den) by restoring division
    function automatic logic [63:0] frac_quotient(input logic [63:0] num,
                                                  input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = 64'd0;
        r = num;
        if (den == 64'd0) return 64'd0;
        for (int i = 0; i < FRAC_BITS_DEF; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // Work out the result, if any, that an accepted character causes
    function automatic void predict_beat(input logic [7:0] c, input logic fin);
        t_fixed_result res;
        logic [63:0]   v;
        if (ph == P_HEAD) begin
            if (head_n >= 3) begin
                ph = P_SIGN;
                if (head_buf[2] == CH_HASH && head_buf[0] == CH_1 &&
                    (head_buf[1] == CH_6 || head_buf[1] == CH_0)) begin
                    hex_on = (head_buf[1] == CH_6);
                    char_n = 3;
                end else begin
                    for (int i = 0; i < 3; i++) parse_char(head_buf[i]);
                end
                parse_char(c);
            end else if (fin) begin
                ph = P_SIGN;
                for (int i = 0; i < head_n; i++) parse_char(head_buf[i]);
                parse_char(c);
            end else begin
                head_buf[head_n] = c;
                head_n++;
                return;
            end
        end else begin
            parse_char(c);
        end
        if (!fin) return;

        if (ph == P_SIGN || ph == P_FIRST) res.status = ST_INCOMPLETE;
        else if (bad_on) res.status = ST_MALFORMED;
        else res.status = ST_OK;

        res.value    = 64'd0;
        res.consumed = 8'd0;
        if (res.status == ST_OK) begin
            v = (int_acc << FRAC_BITS_DEF) | frac_quotient(frac_num, frac_scale);
            v[63] = 1'b0;
            if (neg_on) v = 64'd0 - v;
            res.value    = v;
            res.consumed = 8'(char_n);
        end
        exp_q.push_back(res);
        clear_parser();
    endfunction

    function automatic logic [7:0] digit_char(input int v, input bit upper);
        if (v < 10) return CH_0 + 8'(v);
        return (upper ? CH_UA : CH_LA) + 8'(v - 10);
    endfunction

    // Queue one string as beats, with random gaps in front of them
    task automatic queue_string(input logic [7:0] txt[$], input bit drain);
        t_char_beat b;
        bit         calm;
        calm = ($urandom_range(0, 3) == 0);
        foreach (txt[i]) begin
            b.ch    = txt[i];
            b.last  = (i == txt.size() - 1);
            b.gap   = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
            b.drain = drain && (i == 0);
            pend_q.push_back(b);
        end
        strings_n++;
    endtask

    task automatic queue_text(input string s);
        logic [7:0] txt[$];
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        queue_string(txt, 1'b0);
    endtask

    // Mostly well-formed numbers with random content, some noise
    task automatic queue_random_number(input bit drain);
        logic [7:0] txt[$];
        bit         hx;
        int         nd;
        int         nf;
        int         base;
        int         r;
        hx = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
        end else begin
            r = $urandom_range(0, 5);
            if (r == 1 || r == 2) begin
                txt.push_back(CH_1);
                txt.push_back(CH_6);
                txt.push_back(CH_HASH);
                hx = 1'b1;
            end else if (r == 3) begin
                txt.push_back(CH_1);
                txt.push_back(CH_0);
                txt.push_back(CH_HASH);
            end else if (r == 4) begin
                // near miss of a prefix
                txt.push_back($urandom_range(0, 1) ? CH_1 : 8'($urandom_range(48, 57)));
                txt.push_back(8'($urandom_range(48, 57)));
                txt.push_back($urandom_range(0, 1) ? CH_HASH : 8'($urandom_range(32, 126)));
            end
            base = hx ? 16 : 10;
            r = $urandom_range(0, 3);
            if (r == 1) txt.push_back(CH_MINUS);
            else if (r == 2) txt.push_back(CH_PLUS);
            if ($urandom_range(0, 39) == 0) nd = $urandom_range(250, 300);
            else if ($urandom_range(0, 9) == 0) nd = $urandom_range(15, 25);
            else nd = $urandom_range(0, 6);
            repeat (nd) txt.push_back(digit_char($urandom_range(0, base - 1),
                                                 $urandom_range(0, 1)));
            if ($urandom_range(0, 1)) begin
                txt.push_back(CH_DOT);
                nf = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20)
                                                 : $urandom_range(0, 6);
                repeat (nf) txt.push_back(digit_char($urandom_range(0, base - 1),
                                                     $urandom_range(0, 1)));
                if ($urandom_range(0, 11) == 0) txt.push_back(CH_DOT);
            end
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
        end
        if (txt.size() == 0) txt.push_back(digit_char($urandom_range(0, 9), 1'b0));
        queue_string(txt, drain);
    endtask

    // Send beats from the pending queue and predict each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_beat(i_ch, i_last);
                beats_in++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pend_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (pend_q[0].drain && exp_q.size() != 0) begin
                    // hold off until every result is out
                    i_in_valid <= 1'b0;
                end else if (pend_q[0].gap > 0) begin
                    pend_q[0].gap--;
                    i_in_valid <= 1'b0;
                end else begin
                    next_beat = pend_q.pop_front();
                    i_ch       <= next_beat.ch;
                    i_last     <= next_beat.last;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // Stall the result side in short bursts, with calm stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (beats_in < quiet_from && ((beats_in >> 6) & 3) != 3 &&
                     $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_fixed_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_q.size() == 0) begin
                error_n++;
                $display("%0t: unexpected result value %h status %0d consumed %0d",
                         $time, o_value, o_status, o_consumed);
            end else begin
                want = exp_q.pop_front();
                results_n++;
                if (o_value !== want.value) begin
                    error_n++;
                    $display("%0t: value expected %h actual %h",
                             $time, want.value, o_value);
                end
                if (o_status !== want.status) begin
                    error_n++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                end
                if (o_consumed !== want.consumed) begin
                    error_n++;
                    $display("%0t: consumed expected %0d actual %0d",
                             $time, want.consumed, o_consumed);
                end
            end
        end
    end

    initial begin
        logic [7:0] raw[$];
        int         rand_start;
        int         k;

        clear_parser();

        // Directed strings: prefixes, signs, dots, extremes and odd bytes
        queue_text("16#1F.8");
        queue_text("10#99.25");
        queue_text("-16#7");
        queue_text("16#");
        queue_text("16#-");
        queue_text("10#+");
        queue_text("+");
        queue_text("-");
        queue_text(".5");
        queue_text("1.2.3");
        queue_text("10#x");
        queue_text("12ab");
        queue_text("16#ab.CD");
        queue_text("0.12345678901234567");
        queue_text("16#7FFFFFFFFF.FFFFFF");
        queue_text("16#0.FFFFFFFFFFFFFFFFF");
        queue_text("999999999999999");
        queue_text("-0.5");
        queue_text("5.");
        queue_text("7");
        queue_text("12x.5..");
        raw = '{8'hFF};
        queue_string(raw, 1'b0);
        raw = '{CH_1, 8'h00, CH_DOT, 8'h80};
        queue_string(raw, 1'b0);

        // Random part
        rand_start = pend_q.size();
        k = 0;
        while (pend_q.size() - rand_start < 750) begin
            queue_random_number(k % 12 == 0);
            k++;
        end

        // no idling in the last tenth of the run
        quiet_from = pend_q.size() * 9 / 10;
        for (int i = quiet_from; i < pend_q.size(); i++) begin
            pend_q[i].gap   = 0;
            pend_q[i].drain = 1'b0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || i_in_valid || exp_q.size() != 0) @(posedge i_clk);
        repeat (FRAC_BITS_DEF + 8) @(posedge i_clk);

        $display("Sent %0d strings (%0d characters), checked %0d results.",
                 strings_n, beats_in, results_n);
        $display("Prefixes, signs, dots, long digit runs, noise bytes and stalls exercised.");
        if (error_n == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", exp_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
